// ===== rtl/mhf_pkg.sv =====
// Types and fixed constants for the multichannel high-pass framer.
package mhf_pkg;

  // Input beat fields
  localparam int unsigned CHAN_BITS   = 3;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned S_TDATA_W   = 16;

  // Coefficient register
  localparam int unsigned ALPHA_BITS  = 16;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd65339;

  // Output beat fields
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned VALUE_BITS  = 16;

  // Stored filter output is signed 32-bit fixed point
  localparam int unsigned ACC_BITS    = 32;

  // Byte position inside a three-byte frame
  typedef enum logic [2:0] {
    BEAT_ID = 3'b001,
    BEAT_LO = 3'b010,
    BEAT_HI = 3'b100
  } beat_e;

endpackage

// ===== rtl/multichannel_highpass_framer.sv =====
// Multichannel DC-blocking high-pass filter with three-byte frame output.
//
// Each input beat carries a channel number and a 12-bit sample. Every channel keeps its last
// sample and last output; the new output is alpha * (y_prev + x - x_prev), stored in signed
// Q.FRAC_BITS. The integer part, truncated toward zero and saturated to 16 bits, goes out as
// three beats: channel id, value low byte, value high byte (tlast on the third); tuser carries
// the clip flag on all three. Beats on a channel at or above CHANNELS are taken and dropped.
// A sample is registered on entry, filtered and loaded into the frame register when the
// frame slot frees up; the first byte is offered from there. The byte serialiser sets the
// sustained rate, as each sample goes out as three beats. A sample waits in the input
// register while a frame drains, so the input side keeps taking beats until both are full.
module multichannel_highpass_framer #(
  parameter int CHANNELS  = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // coefficient register write
  input  logic                            cfg_we_i,
  input  logic [mhf_pkg::ALPHA_BITS-1:0]  cfg_wdata_i,
  // sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mhf_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [2:0] channel, [14:3] sample
  // frame byte stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mhf_pkg::BYTE_BITS-1:0]   m_axis_tdata,  // [7:0] out_byte
  output logic                            m_axis_tlast,  // frame_last
  output logic                            m_axis_tuser   // clipped
);

  import mhf_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int D_W      = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int S_W      = ((D_W > ACC_BITS) ? D_W : ACC_BITS) + 1;
  localparam int P_W      = S_W + ALPHA_BITS;
  localparam logic [S_W-1:0] POS_LIM = S_W'(64'h7FFF_FFFF);
  localparam logic [S_W-1:0] NEG_LIM = S_W'(64'h8000_0000);
  localparam logic [ACC_BITS:0] VAL_POS_MAX = (ACC_BITS+1)'(32767);
  localparam logic [ACC_BITS:0] VAL_NEG_MAX = (ACC_BITS+1)'(32768);

  // ---------------------------------------------------------------
  // Coefficient register
  logic [ALPHA_BITS-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // Input register
  logic                   in_vld_q;
  logic [CH_IDX_W-1:0]    in_chan_q;
  logic [SAMPLE_BITS-1:0] in_samp_q;
  logic [CHAN_BITS-1:0]   s_chan;
  logic                   s_chan_ok;
  logic                   s_fire;
  logic                   frame_load;
  logic                   frm_vld_q;
  logic                   m_fire;

  assign s_chan    = s_axis_tdata[CHAN_BITS-1:0];
  assign s_chan_ok = (32'(s_chan) < 32'(CHANNELS));
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign m_fire    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !in_vld_q || frame_load;

  // move the held sample into the frame register when the frame slot frees up
  assign frame_load = in_vld_q && (!frm_vld_q || (m_fire && m_axis_tlast));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= s_chan_ok;
    end else if (frame_load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_chan_ok) begin
      in_chan_q <= CH_IDX_W'(s_chan);
      in_samp_q <= s_axis_tdata[CHAN_BITS +: SAMPLE_BITS];
    end
  end

  // ---------------------------------------------------------------
  // Per-channel filter state
  logic signed [ACC_BITS-1:0] prev_out_q  [CHANNELS];
  logic [SAMPLE_BITS-1:0]     prev_samp_q [CHANNELS];
  logic signed [ACC_BITS-1:0] y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_out_q[i]  <= '0;
        prev_samp_q[i] <= '0;
      end
    end else if (frame_load) begin
      prev_out_q[in_chan_q]  <= y_d;
      prev_samp_q[in_chan_q] <= in_samp_q;
    end
  end

  // ---------------------------------------------------------------
  // Filter datapath: sum, sign-magnitude multiply, saturate, integer part
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [S_W-1:0]       delta_s;
  logic signed [S_W-1:0]       sum_s;
  logic                        sum_neg;
  logic [S_W-1:0]              sum_mag;
  logic [P_W-1:0]              prod;
  logic [S_W-1:0]              prod_mag;
  logic                        y_neg;
  logic [ACC_BITS:0]           y_mag;
  logic [ACC_BITS:0]           i_mag;
  logic [VALUE_BITS-1:0]       val_d;
  logic                        clip_d;

  always_comb begin
    diff    = $signed({1'b0, in_samp_q}) - $signed({1'b0, prev_samp_q[in_chan_q]});
    delta_s = S_W'(diff) <<< FRAC_BITS;
    sum_s   = S_W'(prev_out_q[in_chan_q]) + delta_s;
    sum_neg = sum_s[S_W-1];
    sum_mag = sum_neg ? S_W'(-sum_s) : S_W'(sum_s);

    prod     = P_W'(sum_mag) * P_W'(alpha_q);
    prod_mag = prod[P_W-1:ALPHA_BITS];

    // clamp to the signed 32-bit store, kept as sign and magnitude
    y_neg = sum_neg;
    if (!sum_neg) begin
      y_mag = (prod_mag > POS_LIM) ? POS_LIM[ACC_BITS:0] : prod_mag[ACC_BITS:0];
    end else begin
      y_mag = (prod_mag > NEG_LIM) ? NEG_LIM[ACC_BITS:0] : prod_mag[ACC_BITS:0];
    end
    y_d = y_neg ? ACC_BITS'((ACC_BITS+1)'(0) - y_mag) : y_mag[ACC_BITS-1:0];

    // integer part, truncated toward zero
    i_mag = y_mag >> FRAC_BITS;

    // 16-bit saturation with clip flag
    clip_d = 1'b0;
    if (!y_neg && (i_mag > VAL_POS_MAX)) begin
      val_d  = 16'h7FFF;
      clip_d = 1'b1;
    end else if (y_neg && (i_mag > VAL_NEG_MAX)) begin
      val_d  = 16'h8000;
      clip_d = 1'b1;
    end else if (y_neg) begin
      val_d = VALUE_BITS'((ACC_BITS+1)'(0) - i_mag);
    end else begin
      val_d = i_mag[VALUE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Frame register and byte serialiser
  beat_e                 beat_q;
  beat_e                 beat_d;
  logic                  frm_vld_d;
  logic [CH_IDX_W-1:0]   frm_chan_q;
  logic [VALUE_BITS-1:0] frm_val_q;
  logic                  frm_clip_q;

  always_comb begin
    beat_d    = beat_q;
    frm_vld_d = frm_vld_q;
    if (frame_load) begin
      beat_d    = BEAT_ID;
      frm_vld_d = 1'b1;
    end else if (m_fire) begin
      case (beat_q)
        BEAT_ID: beat_d = BEAT_LO;
        BEAT_LO: beat_d = BEAT_HI;
        BEAT_HI: begin
          beat_d    = BEAT_ID;
          frm_vld_d = 1'b0;
        end
        default: beat_d = BEAT_ID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q    <= BEAT_ID;
      frm_vld_q <= 1'b0;
    end else begin
      beat_q    <= beat_d;
      frm_vld_q <= frm_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_load) begin
      frm_chan_q <= in_chan_q;
      frm_val_q  <= val_d;
      frm_clip_q <= clip_d;
    end
  end

  // Output beat mux
  always_comb begin
    case (beat_q)
      BEAT_ID: m_axis_tdata = BYTE_BITS'(frm_chan_q);
      BEAT_LO: m_axis_tdata = frm_val_q[BYTE_BITS-1:0];
      BEAT_HI: m_axis_tdata = frm_val_q[VALUE_BITS-1:BYTE_BITS];
      default: m_axis_tdata = '0;
    endcase
  end

  assign m_axis_tvalid = frm_vld_q;
  assign m_axis_tlast  = (beat_q == BEAT_HI);
  assign m_axis_tuser  = frm_clip_q;

  // ---------------------------------------------------------------
  // Assertions
`ifndef ASSERT_OFF
  // a new frame always opens with the channel id byte
  a_load_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_load |=> (m_axis_tvalid && (beat_q == BEAT_ID)))
    else $error("frame load did not start at the id byte");

  // the stream goes idle after the last byte unless another frame was ready
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast && !frame_load) |=> !m_axis_tvalid)
    else $error("output stayed valid after frame end");

  // clip flag holds across every byte of one frame
  a_clip_per_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !frame_load) |=> $stable(m_axis_tuser))
    else $error("clip flag changed inside a frame");
`endif

endmodule

// ===== verif/highpass_frame_checker.sv =====
// Checker for the high-pass framer: predicts each frame and compares the byte stream.
module highpass_frame_checker #(
  parameter int CHANNELS  = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mhf_pkg::ALPHA_BITS-1:0]  cfg_wdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [mhf_pkg::S_TDATA_W-1:0]   s_tdata_i,   // [2:0] channel, [14:3] sample
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [mhf_pkg::BYTE_BITS-1:0]   m_tdata_i,   // [7:0] out_byte
  input  logic                            m_tlast_i,   // frame_last
  input  logic                            m_tuser_i,   // clipped
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;
  localparam longint VAL_MAX = 64'sd32767;
  localparam longint VAL_MIN = -64'sd32768;

  typedef struct packed {
    logic [mhf_pkg::VALUE_BITS-1:0] value;
    logic                           clip;
  } filtered_t;

  typedef struct packed {
    logic [mhf_pkg::BYTE_BITS-1:0] data;
    logic                          last;
    logic                          clip;
  } frame_beat_t;

  // Model copy of the coefficient and the per-channel filter history
  logic [mhf_pkg::ALPHA_BITS-1:0]  alpha_q;
  int                              last_out [CHANNELS];
  logic [mhf_pkg::SAMPLE_BITS-1:0] last_sample [CHANNELS];

  frame_beat_t frame_bytes_q [$];
  frame_beat_t want;
  filtered_t   filt;
  logic [mhf_pkg::CHAN_BITS-1:0]   in_chan;
  logic [mhf_pkg::SAMPLE_BITS-1:0] in_sample;
  int          fails;

  // One filter step on a channel; updates that channel's history
  function automatic filtered_t filter_sample(input int ch,
                                              input logic [mhf_pkg::SAMPLE_BITS-1:0] x);
    longint          delta;
    longint          acc;
    longint          y;
    longint          iv;
    longint unsigned mag;
    longint unsigned prod;
    filtered_t       res;
    delta = longint'(x) - longint'(last_sample[ch]);
    acc   = longint'(last_out[ch]) + delta * (longint'(1) <<< FRAC_BITS);
    // magnitude times alpha, truncated toward zero
    mag   = (acc < 0) ? longint'(-acc) : acc;
    prod  = (mag * longint'(alpha_q)) >> mhf_pkg::ALPHA_BITS;
    y     = (acc < 0) ? -longint'(prod) : longint'(prod);
    if (y > ACC_MAX) y = ACC_MAX;
    if (y < ACC_MIN) y = ACC_MIN;
    last_out[ch]    = int'(y);
    last_sample[ch] = x;
    // integer part toward zero, then 16-bit saturation
    mag = (y < 0) ? longint'(-y) : y;
    iv  = longint'(mag >> FRAC_BITS);
    if (y < 0) iv = -iv;
    res.clip = 1'b0;
    if (iv > VAL_MAX) begin
      iv       = VAL_MAX;
      res.clip = 1'b1;
    end else if (iv < VAL_MIN) begin
      iv       = VAL_MIN;
      res.clip = 1'b1;
    end
    res.value = iv[mhf_pkg::VALUE_BITS-1:0];
    return res;
  endfunction

  // Watch both streams and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q = mhf_pkg::ALPHA_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        last_out[i]    = 0;
        last_sample[i] = '0;
      end
      frame_bytes_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) alpha_q = cfg_wdata_i;

      // accepted sample on a valid channel: queue its three frame bytes
      if (s_tvalid_i && s_tready_i) begin
        in_chan   = s_tdata_i[mhf_pkg::CHAN_BITS-1:0];
        in_sample = s_tdata_i[mhf_pkg::CHAN_BITS +: mhf_pkg::SAMPLE_BITS];
        if (int'(in_chan) < CHANNELS) begin
          filt = filter_sample(int'(in_chan), in_sample);
          frame_bytes_q.push_back('{data: {5'b0, in_chan}, last: 1'b0, clip: filt.clip});
          frame_bytes_q.push_back('{data: filt.value[7:0], last: 1'b0, clip: filt.clip});
          frame_bytes_q.push_back('{data: filt.value[15:8], last: 1'b1, clip: filt.clip});
        end
      end

      // accepted frame byte: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t: unexpected beat, got byte %h last %b clip %b",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
          fails++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (m_tdata_i !== want.data) begin
            $display("%0t: out_byte expected %h got %h", $time, want.data, m_tdata_i);
            fails++;
          end
          if (m_tlast_i !== want.last) begin
            $display("%0t: frame_last expected %b got %b", $time, want.last, m_tlast_i);
            fails++;
          end
          if (m_tuser_i !== want.clip) begin
            $display("%0t: clipped expected %b got %b", $time, want.clip, m_tuser_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= frame_bytes_q.size();
    end
  end

endmodule

// ===== verif/tb_multichannel_highpass_framer.sv =====
// Testbench top for the multichannel high-pass framer: stimulus, idling and verdict.
module tb_multichannel_highpass_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS     = 6;
  localparam int FRAC_BITS    = 16;
  localparam int PHASE_ITEMS  = 50;
  localparam int IDLE_LIMIT   = 500;
  localparam int SETTLE_TICKS = 10;
  localparam int SAMPLE_MAX   = 4095;
  localparam int SAMPLE_W     = mhf_pkg::SAMPLE_BITS;
  localparam int CHAN_W       = mhf_pkg::CHAN_BITS;
  localparam int ALPHA_W      = mhf_pkg::ALPHA_BITS;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [mhf_pkg::ALPHA_BITS-1:0]  cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [mhf_pkg::S_TDATA_W-1:0]   s_axis_tdata;   // [2:0] channel, [14:3] sample
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [mhf_pkg::BYTE_BITS-1:0]   m_axis_tdata;   // [7:0] out_byte
  logic                            m_axis_tlast;   // frame_last
  logic                            m_axis_tuser;   // clipped

  int fail_count;
  int pending;
  int idle_ticks = 0;
  bit sender_steady;
  bit receiver_steady;

  logic [mhf_pkg::ALPHA_BITS-1:0] alpha_plan [7];

  multichannel_highpass_framer #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  highpass_frame_checker #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_ticks <= 0;
      end else if (idle_ticks >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_ticks <= idle_ticks + 1;
      end
    end
  end

  // Receiver: random stall before each frame byte, with stall-free stretches
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    receiver_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) receiver_steady = !receiver_steady;
      stall = receiver_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Send one sample beat; called and returns at a falling edge
  task automatic send_sample(input logic [mhf_pkg::CHAN_BITS-1:0] ch,
                             input logic [mhf_pkg::SAMPLE_BITS-1:0] smp);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, smp, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted byte has come out
  task automatic await_frames_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_alpha(input logic [mhf_pkg::ALPHA_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mix of full-range, rail, small and single-bit samples
  function automatic logic [mhf_pkg::SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(0);
      1:       return SAMPLE_W'($urandom_range(0, 15));
      2:       return 12'd1 << $urandom_range(0, mhf_pkg::SAMPLE_BITS - 1);
      default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  // Mostly valid channels, some out of range
  function automatic logic [mhf_pkg::CHAN_BITS-1:0] draw_channel();
    if ($urandom_range(0, 9) == 0) return CHAN_W'($urandom_range(CHANNELS, 7));
    return CHAN_W'($urandom_range(0, CHANNELS - 1));
  endfunction

  // Main stimulus
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_steady = 1'b0;
    alpha_plan    = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001,
                      16'h0000, 16'h0000, mhf_pkg::ALPHA_RESET};
    alpha_plan[4] = ALPHA_W'($urandom_range(0, 16'hFFFF));
    alpha_plan[5] = ALPHA_W'($urandom_range(16'hF000, 16'hFFFF));
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, reset coefficient: full-scale rise on every channel, then fall
    for (int c = 0; c < CHANNELS; c++) send_sample(CHAN_W'(c), SAMPLE_W'(SAMPLE_MAX));
    for (int c = 0; c < CHANNELS; c++) send_sample(CHAN_W'(c), '0);
    // out-of-range channels are dropped
    send_sample(3'd6, 12'hABC);
    send_sample(3'd7, SAMPLE_W'(SAMPLE_MAX));
    // mid-scale step, then a held sample that only decays
    send_sample(3'd0, 12'd2048);
    send_sample(3'd1, SAMPLE_W'(SAMPLE_MAX));
    send_sample(3'd1, SAMPLE_W'(SAMPLE_MAX));
    send_sample(3'd1, SAMPLE_W'(SAMPLE_MAX));
    send_sample(3'd7, 12'h000);

    // Random phases, one coefficient setting each
    foreach (alpha_plan[p]) begin
      await_frames_drained();
      write_alpha(alpha_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 24) == 0) sender_steady = !sender_steady;
        if (n == PHASE_ITEMS / 2 && p == 2) await_frames_drained();
        send_sample(draw_channel(), draw_sample());
      end
    end

    await_frames_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mhf_pkg.sv
rtl/multichannel_highpass_framer.sv
verif/highpass_frame_checker.sv
verif/tb_multichannel_highpass_framer.sv
